### rtl/core/tcp_option_mss_parser_defines.svh
// ---------------------------------------------------------------------------
// TCP option MSS parser assertion macros
// Shared concurrent assertion forms for the option parser.
// ---------------------------------------------------------------------------
`ifndef TCP_OPTION_MSS_PARSER_DEFINES_SVH
`define TCP_OPTION_MSS_PARSER_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define TOMP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TOMP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/tomp_pkg.sv
// ---------------------------------------------------------------------------
// TCP option MSS parser package
// Field widths, option kind codes, parse phases and the item structures.
// ---------------------------------------------------------------------------
package tomp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned MSS_W  = 16;

  // Option kind codes.
  localparam logic [BYTE_W-1:0] KIND_END = 8'h00;
  localparam logic [BYTE_W-1:0] KIND_NOP = 8'h01;
  localparam logic [BYTE_W-1:0] KIND_MSS = 8'h02;

  // Lengths and offsets within an option.
  localparam logic [BYTE_W-1:0] LEN_MIN       = 8'd2;
  localparam logic [BYTE_W-1:0] MSS_MIN_LEN   = 8'd4;
  localparam logic [BYTE_W-1:0] OFS_LEN       = 8'd1;
  localparam logic [BYTE_W-1:0] OFS_MSS_HIGH  = 8'd2;
  localparam logic [BYTE_W-1:0] OFS_MSS_LOW   = 8'd3;

  // Parse phase, one-hot.
  typedef enum logic [3:0] {
    PH_KIND = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_BODY = 4'b0100,
    PH_STOP = 4'b1000
  } phase_t;

  // One option byte with its marks and the stored MSS.
  typedef struct packed {
    logic [BYTE_W-1:0] option_byte;
    logic              first_byte;
    logic              last_byte;
    logic [MSS_W-1:0]  current_mss;
  } option_item_t;

  // One parse result.
  typedef struct packed {
    logic [MSS_W-1:0] new_mss;
    logic             mss_reduced;
    logic             malformed;
  } mss_result_t;

endpackage

### rtl/core/tomp_option_if.sv
// ---------------------------------------------------------------------------
// Option byte channel
// Valid/ready channel carrying one option byte per request.
// ---------------------------------------------------------------------------
interface tomp_option_if;
  import tomp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] option_byte;
  logic              first_byte;
  logic              last_byte;
  logic [MSS_W-1:0]  current_mss;

  modport source (
    output valid, option_byte, first_byte, last_byte, current_mss,
    input  ready
  );

  modport sink (
    input  valid, option_byte, first_byte, last_byte, current_mss,
    output ready
  );

endinterface

### rtl/core/tomp_result_if.sv
// ---------------------------------------------------------------------------
// MSS result channel
// Valid/ready channel carrying one parse result per request.
// ---------------------------------------------------------------------------
interface tomp_result_if;
  import tomp_pkg::*;

  logic             valid;
  logic             ready;
  logic [MSS_W-1:0] new_mss;
  logic             mss_reduced;
  logic             malformed;

  modport source (
    output valid, new_mss, mss_reduced, malformed,
    input  ready
  );

  modport sink (
    input  valid, new_mss, mss_reduced, malformed,
    output ready
  );

endinterface

### rtl/core/tcp_option_mss_parser.sv
// ---------------------------------------------------------------------------
// TCP option MSS parser
// Walks the TCP option area byte by byte and reports the reduced MSS.
// ---------------------------------------------------------------------------
// The parser takes one option byte per cycle, save for the stall below: a
// byte is held in an input register, the walker updates its parse state
// from it in one pass, and a byte marked last loads the result register
// as the walker consumes it. The first byte of an area restarts the walk
// and samples the stored MSS; the result carries the smallest MSS seen,
// whether a received MSS lowered it, and whether a bad option length
// stopped the walk. Only a result that waits in the output register can
// stall the input, and only for a last byte.
`include "tcp_option_mss_parser_defines.svh"

module tcp_option_mss_parser (
  input  logic          clk,
  input  logic          rst,
  tomp_option_if.sink   options,
  tomp_result_if.source result
);
  import tomp_pkg::*;

  logic         held_valid;
  option_item_t held_item;
  logic         advance;
  logic         can_load;
  mss_result_t  outcome;

  // A held byte is consumed unless it is a last byte with no room for its result.
  assign advance = held_valid && (!held_item.last_byte || can_load);

  tomp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .options    (options),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  tomp_walker u_walker (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .item    (held_item),
    .outcome (outcome)
  );

  tomp_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && held_item.last_byte),
    .outcome  (outcome),
    .can_load (can_load),
    .result   (result)
  );

  // A new result only ever comes from a consumed last byte.
  `TOMP_ASSERT(a_result_from_last, clk, rst,
    $rose(result.valid) |-> $past(advance && held_item.last_byte),
    "Result appeared without a consumed last byte")

  // A byte that is not consumed stays in the input register unchanged.
  `TOMP_ASSERT(a_held_byte_kept, clk, rst,
    held_valid && !advance |=> held_valid && $stable(held_item),
    "Held option byte was lost or overwritten")

  // With the result register empty the input side never stalls.
  `TOMP_ASSERT(a_no_stall_when_empty, clk, rst,
    !result.valid |-> options.ready,
    "Input stalled while the result register was empty")

endmodule

### rtl/core/tomp_in_stage.sv
// ---------------------------------------------------------------------------
// Input register
// Holds one accepted option byte until the walker consumes it.
// ---------------------------------------------------------------------------
module tomp_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  tomp_option_if.sink           options,
  input  logic                  advance,
  output logic                  held_valid,
  output tomp_pkg::option_item_t held_item
);
  import tomp_pkg::*;

  logic accept;

  // The register frees up in the same cycle as it is consumed.
  assign options.ready = !held_valid || advance;
  assign accept        = options.valid && options.ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      held_item.option_byte <= options.option_byte;
      held_item.first_byte  <= options.first_byte;
      held_item.last_byte   <= options.last_byte;
      held_item.current_mss <= options.current_mss;
    end
  end

endmodule

### rtl/core/tomp_walker.sv
// ---------------------------------------------------------------------------
// Option walker
// Parse state and the one-byte update of the option walk.
// ---------------------------------------------------------------------------
module tomp_walker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  tomp_pkg::option_item_t item,
  output tomp_pkg::mss_result_t  outcome
);
  import tomp_pkg::*;

  phase_t            phase;
  phase_t            phase_base;
  phase_t            phase_next;
  logic [BYTE_W-1:0] offset;
  logic [BYTE_W-1:0] offset_base;
  logic [BYTE_W-1:0] offset_next;
  logic [BYTE_W-1:0] length;
  logic [BYTE_W-1:0] length_base;
  logic [BYTE_W-1:0] length_next;
  logic              is_mss;
  logic              is_mss_base;
  logic              is_mss_next;
  logic [BYTE_W-1:0] mss_high;
  logic [BYTE_W-1:0] mss_high_base;
  logic [BYTE_W-1:0] mss_high_next;
  logic [MSS_W-1:0]  running_mss;
  logic [MSS_W-1:0]  running_mss_base;
  logic [MSS_W-1:0]  running_mss_next;
  logic              reduced;
  logic              reduced_base;
  logic              reduced_next;
  logic              malformed;
  logic              malformed_base;
  logic              malformed_next;
  logic [BYTE_W-1:0] b;
  logic [MSS_W-1:0]  received_mss;

  assign b            = item.option_byte;
  assign received_mss = {mss_high_base, b};

  // A first byte restarts the parse from the stored MSS.
  always_comb begin
    if (item.first_byte) begin
      phase_base       = PH_KIND;
      offset_base      = '0;
      length_base      = '0;
      is_mss_base      = 1'b0;
      mss_high_base    = '0;
      running_mss_base = item.current_mss;
      reduced_base     = 1'b0;
      malformed_base   = 1'b0;
    end else begin
      phase_base       = phase;
      offset_base      = offset;
      length_base      = length;
      is_mss_base      = is_mss;
      mss_high_base    = mss_high;
      running_mss_base = running_mss;
      reduced_base     = reduced;
      malformed_base   = malformed;
    end
  end

  // One byte of the option walk.
  always_comb begin
    phase_next       = phase_base;
    offset_next      = offset_base;
    length_next      = length_base;
    is_mss_next      = is_mss_base;
    mss_high_next    = mss_high_base;
    running_mss_next = running_mss_base;
    reduced_next     = reduced_base;
    malformed_next   = malformed_base;
    unique case (phase_base)
      PH_KIND: begin
        if (b == KIND_END) begin
          phase_next = PH_STOP;
        end else if (b != KIND_NOP) begin
          is_mss_next = (b == KIND_MSS);
          offset_next = OFS_LEN;
          phase_next  = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b < LEN_MIN) begin
          // A length that cannot cover its own header stops the walk.
          malformed_next = 1'b1;
          phase_next     = PH_STOP;
        end else begin
          length_next = b;
          if (b < MSS_MIN_LEN) begin
            is_mss_next = 1'b0;
          end
          if (b == LEN_MIN) begin
            phase_next = PH_KIND;
          end else begin
            offset_next = OFS_MSS_HIGH;
            phase_next  = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (is_mss_base) begin
          if (offset_base == OFS_MSS_HIGH) begin
            mss_high_next = b;
          end else if (offset_base == OFS_MSS_LOW) begin
            if (received_mss < running_mss_base) begin
              running_mss_next = received_mss;
              reduced_next     = 1'b1;
            end
          end
        end
        offset_next = offset_base + 8'd1;
        if (offset_next >= length_base) begin
          phase_next = PH_KIND;
        end
      end
      PH_STOP: begin
        phase_next = PH_STOP;
      end
      default: begin
        phase_next = PH_KIND;
      end
    endcase
  end

  assign outcome.new_mss     = running_mss_next;
  assign outcome.mss_reduced = reduced_next;
  assign outcome.malformed   = malformed_next;

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_KIND;
      offset      <= '0;
      length      <= '0;
      is_mss      <= 1'b0;
      mss_high    <= '0;
      running_mss <= '0;
      reduced     <= 1'b0;
      malformed   <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      offset      <= offset_next;
      length      <= length_next;
      is_mss      <= is_mss_next;
      mss_high    <= mss_high_next;
      running_mss <= running_mss_next;
      reduced     <= reduced_next;
      malformed   <= malformed_next;
    end
  end

endmodule

### rtl/core/tomp_out_stage.sv
// ---------------------------------------------------------------------------
// Result register
// Holds one parse result until the downstream side takes it.
// ---------------------------------------------------------------------------
module tomp_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  tomp_pkg::mss_result_t outcome,
  output logic                  can_load,
  tomp_result_if.source         result
);
  import tomp_pkg::*;

  // Free when empty or being emptied this cycle.
  assign can_load = !result.valid || result.ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (load) begin
      result.new_mss     <= outcome.new_mss;
      result.mss_reduced <= outcome.mss_reduced;
      result.malformed   <= outcome.malformed;
    end
  end

endmodule
